// ===== rtl/handle_table_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Handle table allocator assertion macros
// Shared concurrent assertion forms for the handle table checker.
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_TOP_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define HTA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define HTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hta_pkg.sv =====
// ----------------------------------------------------------------------------
// Handle table allocator package
// Sizes, codes and item types shared by the handle table modules.
// ----------------------------------------------------------------------------
package hta_pkg;

    // Table geometry. Slot 0 exists but is never handed out.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    // Valid bits are kept in rows so that a whole row is searched at once.
    localparam int ROW_BITS    = (TABLE_SLOTS >= 64) ? 32 : (TABLE_SLOTS / 2);
    localparam int BIT_W       = $clog2(ROW_BITS);
    localparam int ROWS        = TABLE_SLOTS / ROW_BITS;
    localparam int ROW_W       = SLOT_W - BIT_W;

    // Request kinds.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_GET    = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Special handles.
    localparam logic [31:0] H_CUR_THREAD  = 32'hFFFF_FFFE;
    localparam logic [31:0] H_CUR_PROCESS = 32'hFFFF_FFFF;

    // Operation that the front end hands to the back end.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_GET,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       object_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] handle;
        logic [31:0] object_id;
        logic [31:0] current_thread_handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_out;
        logic [31:0] object_out;
    } out_item_t;

endpackage

// ===== rtl/hta_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hta_front.sv =====
// ----------------------------------------------------------------------------
// Handle table front end
// Accepts request items, resolves the handle to a slot and queues commands.
// ----------------------------------------------------------------------------
module hta_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hta_pkg::in_item_t s_item,
    output logic              cmd_valid,
    output hta_pkg::cmd_t     cmd,
    input  logic              cmd_pop
);
    import hta_pkg::*;

    localparam int HI_W = 32 - 2 - SLOT_W;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic [31:0] eff_handle;
    logic        in_range;
    cmd_t        new_cmd;

    // Classify the incoming item. The current-thread handle is substituted on
    // get before the range check, and the current-process handle is rejected.
    always_comb begin
        eff_handle = s_item.handle;
        if (s_item.kind == KIND_GET && s_item.handle == H_CUR_THREAD) begin
            eff_handle = s_item.current_thread_handle;
        end
        in_range = (eff_handle[31 -: HI_W] == '0);
        new_cmd.slot      = eff_handle[2 +: SLOT_W];
        new_cmd.object_id = s_item.object_id;
        case (s_item.kind)
            KIND_ADD: begin
                new_cmd.op = OP_ADD;
            end
            KIND_REMOVE: begin
                new_cmd.op = in_range ? OP_REMOVE : OP_REJECT;
            end
            KIND_GET: begin
                new_cmd.op = (in_range && s_item.handle != H_CUR_PROCESS) ? OP_GET
                                                                          : OP_REJECT;
            end
            default: begin
                new_cmd.op = OP_REJECT;
            end
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Two-entry command queue between the front and back ends.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !cmd_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!push && cmd_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== rtl/hta_back.sv =====
// ----------------------------------------------------------------------------
// Handle table back end
// Executes queued commands against the valid-row and object memories.
// ----------------------------------------------------------------------------
module hta_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  hta_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output hta_pkg::out_item_t m_item
);
    import hta_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } state_t;

    localparam int PAD_W = 32 - 2 - SLOT_W;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ROWS-1:0]     row_init_reg;
    logic [ROWS-1:0]     row_full_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    logic                go;
    logic                fast_done;
    logic                any_free_row;
    logic [ROW_W-1:0]    free_row;
    logic                vld_rd_en;
    logic [ROW_W-1:0]    vld_rd_addr;
    logic [ROW_BITS-1:0] vld_rd_data;
    logic                vld_wr_en;
    logic [ROW_BITS-1:0] vld_wr_data;
    logic                obj_wr_en;
    logic [SLOT_W-1:0]   obj_wr_addr;
    logic [31:0]         obj_rd_data;
    logic [ROW_BITS-1:0] row_bits;
    logic [ROW_BITS-1:0] occupied;
    logic [BIT_W-1:0]    free_bit;
    logic [BIT_W-1:0]    req_bit;
    logic                hit;
    logic [SLOT_W-1:0]   new_slot;

    // Lowest row whose full flag is clear.
    function automatic logic [ROW_W-1:0] first_open_row(input logic [ROWS-1:0] full);
        logic [ROW_W-1:0] idx;
        idx = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!full[i]) begin
                idx = ROW_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest clear bit of a row.
    function automatic logic [BIT_W-1:0] first_clear_bit(input logic [ROW_BITS-1:0] bits);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!bits[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Command issue: a new command starts once the output register frees up.
    assign go           = (state_reg == S_IDLE) && cmd_valid && (!out_valid_reg || m_ready);
    assign cmd_pop      = go;
    assign any_free_row = !(&row_full_reg);
    assign free_row     = first_open_row(row_full_reg);
    assign vld_rd_en    = go;
    assign vld_rd_addr  = (cmd.op == OP_ADD) ? free_row : cmd.slot[SLOT_W-1 -: ROW_W];

    // A rejected command or an add to a full table is answered at issue.
    assign fast_done = go && ((cmd.op == OP_REJECT) || (cmd.op == OP_ADD && !any_free_row));

    // Row decode in the lookup cycle. A row never written reads as all free,
    // and slot 0 is always treated as taken by the search.
    always_comb begin
        row_bits = row_init_reg[row_reg] ? vld_rd_data : '0;
        occupied = row_bits;
        if (row_reg == '0) begin
            occupied[0] = 1'b1;
        end
        free_bit = first_clear_bit(occupied);
        req_bit  = cmd_reg.slot[BIT_W-1:0];
        hit      = row_bits[req_bit];
        new_slot = {row_reg, free_bit};

        vld_wr_en   = 1'b0;
        vld_wr_data = row_bits;
        obj_wr_en   = 1'b0;
        obj_wr_addr = new_slot;
        if (state_reg == S_LOOKUP) begin
            case (cmd_reg.op)
                OP_ADD: begin
                    vld_wr_en             = 1'b1;
                    vld_wr_data[free_bit] = 1'b1;
                    obj_wr_en             = 1'b1;
                end
                OP_REMOVE: begin
                    vld_wr_en            = hit;
                    vld_wr_data[req_bit] = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    hta_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_valid_ram (
        .aclk    (aclk),
        .wr_en   (vld_wr_en),
        .wr_addr (row_reg),
        .wr_data (vld_wr_data),
        .rd_en   (vld_rd_en),
        .rd_addr (vld_rd_addr),
        .rd_data (vld_rd_data)
    );

    hta_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_SLOTS)
    ) u_object_ram (
        .aclk    (aclk),
        .wr_en   (obj_wr_en),
        .wr_addr (obj_wr_addr),
        .wr_data (cmd_reg.object_id),
        .rd_en   (go),
        .rd_addr (cmd.slot),
        .rd_data (obj_rd_data)
    );

    // Sequencer, row flags and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_init_reg  <= '0;
            row_full_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fast_done || state_reg == S_LOOKUP) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (go) begin
                        cmd_reg <= cmd;
                        row_reg <= vld_rd_addr;
                        if (fast_done) begin
                            // Answered without touching the memories.
                            out_item_reg.status     <= (cmd.op == OP_ADD) ? ST_FULL
                                                                          : ST_INVALID;
                            out_item_reg.handle_out <= '0;
                            out_item_reg.object_out <= '0;
                        end else begin
                            state_reg <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP: begin
                    state_reg <= S_IDLE;
                    case (cmd_reg.op)
                        OP_ADD: begin
                            row_init_reg[row_reg]   <= 1'b1;
                            row_full_reg[row_reg]   <= &(occupied | (ROW_BITS'(1) << free_bit));
                            out_item_reg.status     <= ST_OK;
                            out_item_reg.handle_out <= {{PAD_W{1'b0}}, new_slot, 2'b00};
                            out_item_reg.object_out <= '0;
                        end
                        OP_REMOVE: begin
                            if (hit) begin
                                row_full_reg[row_reg] <= 1'b0;
                            end
                            out_item_reg.status     <= hit ? ST_OK : ST_INVALID;
                            out_item_reg.handle_out <= '0;
                            out_item_reg.object_out <= '0;
                        end
                        OP_GET: begin
                            out_item_reg.status     <= hit ? ST_OK : ST_INVALID;
                            out_item_reg.handle_out <= '0;
                            out_item_reg.object_out <= hit ? obj_rd_data : '0;
                        end
                        default: begin
                            out_item_reg.status     <= ST_INVALID;
                            out_item_reg.handle_out <= '0;
                            out_item_reg.object_out <= '0;
                        end
                    endcase
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// ===== rtl/handle_table_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Handle table allocator
// Fixed-size object handle table with add, remove and get requests.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   in_item_t  (kind, handle, ids)
// m_        out        m_valid / m_ready   out_item_t (status, handle, object)
//
// A result passes through the command queue, the registered read of the
// valid-row memory at issue, and the lookup and update state, and is then
// held in the result register. A rejected or table-full item is answered at
// issue, with no lookup. The back end issues no new command while one is in
// lookup or while a held result waits on m_ready. Free-slot search uses
// per-row full flags, so an add never walks the table. Rows carry init
// flags, so reset runs no clearing pass. Up to two items queue while a
// result waits on m_ready.
// ----------------------------------------------------------------------------
module handle_table_allocator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hta_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output hta_pkg::out_item_t m_item
);
    import hta_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // Request classification and queue.
    hta_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Table execution and result register.
    hta_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== rtl/hta_checker.sv =====
// ----------------------------------------------------------------------------
// Handle table checker
// Port-level assertions on the result channel of the handle table.
// ----------------------------------------------------------------------------
`include "handle_table_allocator_top_macros.svh"

module hta_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input hta_pkg::out_item_t m_item
);
    import hta_pkg::*;

    // A stalled result stays put.
    `HTA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "stalled result changed")

    // Only defined status codes appear.
    `HTA_ASSERT_NOW(a_status, aclk, aresetn, m_valid, m_item.status == ST_OK || m_item.status == ST_INVALID || m_item.status == ST_FULL, "undefined status")

    // A failed request carries no handle and no object.
    `HTA_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid && m_item.status != ST_OK, m_item.handle_out == '0 && m_item.object_out == '0, "failed result not zeroed")

    // An allocated handle is slot aligned and never names slot 0, and an add
    // result carries no object.
    `HTA_ASSERT_NOW(a_handle, aclk, aresetn, m_valid && m_item.handle_out != '0, m_item.handle_out[1:0] == 2'b00 && m_item.object_out == '0 && m_item.handle_out[31:2] < 30'(TABLE_SLOTS), "bad allocated handle")

endmodule

bind handle_table_allocator_top hta_checker u_hta_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ===== verif/handle_table_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// Handle table allocator testbench
// Drives add, remove and get requests through the valid/ready request port,
// predicts every response from a local copy of the slot table, and compares
// each response field by field. Phases swap sender and receiver stalls, then
// run without stalls on either side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module handle_table_allocator_top_tb;

    import hta_pkg::*;

    // Kind code that the block must reject.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         TAIL_CYCLES = 16;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Predicted table contents and the responses still owed by the block.
    bit          slot_live [TABLE_SLOTS];
    logic [31:0] slot_object [TABLE_SLOTS];
    int          live_count;
    out_item_t   pending_responses [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int failures = 0;
    int request_count = 0;
    int ok_count = 0;
    int invalid_count = 0;
    int full_count = 0;

    handle_table_allocator_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Free-running clock, 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run limit so that a hung handshake cannot stall the simulation.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycle_count, pending_responses.size());
            $display("handle_table_allocator_top verification failed");
            $finish;
        end
    end

    // Receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Apply one request to the predicted table and return its response.
    function automatic out_item_t predict_response(in_item_t req);
        out_item_t   rsp;
        logic [31:0] target;
        int unsigned slot;
        rsp.status     = ST_INVALID;
        rsp.handle_out = '0;
        rsp.object_out = '0;
        case (req.kind)
            KIND_ADD: begin
                // Lowest free slot wins; slot zero is never handed out.
                rsp.status = ST_FULL;
                for (int i = 1; i < TABLE_SLOTS; i++) begin
                    if (!slot_live[i]) begin
                        slot_live[i]   = 1'b1;
                        slot_object[i] = req.object_id;
                        live_count++;
                        rsp.handle_out = 32'(i) << 2;
                        rsp.status     = ST_OK;
                        break;
                    end
                end
            end
            KIND_REMOVE: begin
                slot = req.handle >> 2;
                if (slot < TABLE_SLOTS && slot_live[slot]) begin
                    slot_live[slot]   = 1'b0;
                    slot_object[slot] = '0;
                    live_count--;
                    rsp.status = ST_OK;
                end
            end
            KIND_GET: begin
                // The current-process handle is never valid; the current-thread
                // handle is replaced by the supplied thread handle.
                if (req.handle != H_CUR_PROCESS) begin
                    target = (req.handle == H_CUR_THREAD) ? req.current_thread_handle
                                                           : req.handle;
                    slot = target >> 2;
                    if (slot < TABLE_SLOTS && slot_live[slot]) begin
                        rsp.object_out = slot_object[slot];
                        rsp.status     = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // Handle of a random live slot with random low bits, or any in-range
    // handle when the table is empty.
    function automatic logic [31:0] live_handle();
        int unsigned start;
        int unsigned slot;
        start = $urandom_range(TABLE_SLOTS - 1);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot = (start + i) % TABLE_SLOTS;
            if (slot_live[slot])
                return (32'(slot) << 2) | 32'($urandom_range(3));
        end
        return 32'($urandom_range(TABLE_SLOTS * 4 - 1));
    endfunction

    // Mostly well-formed traffic on live handles, with invalid handles,
    // special handles and the unused kind mixed in.
    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        req.kind                  = KIND_ADD;
        req.handle                = $urandom();
        req.object_id             = $urandom();
        req.current_thread_handle = $urandom();
        pick = $urandom_range(99);
        if (pick < 35) begin
            req.kind = KIND_ADD;
        end else if (pick < 55) begin
            req.kind = KIND_GET;
            if ($urandom_range(3) == 0) begin
                req.handle                = H_CUR_THREAD;
                req.current_thread_handle = live_handle();
            end else begin
                req.handle = live_handle();
            end
        end else if (pick < 70) begin
            req.kind   = KIND_REMOVE;
            req.handle = live_handle();
        end else if (pick < 80) begin
            req.kind   = $urandom_range(1) ? KIND_GET : KIND_REMOVE;
            req.handle = 32'($urandom_range(TABLE_SLOTS * 4 - 1));
        end else if (pick < 90) begin
            req.kind = $urandom_range(1) ? KIND_GET : KIND_REMOVE;
        end else if (pick < 95) begin
            req.kind   = KIND_GET;
            req.handle = $urandom_range(1) ? H_CUR_PROCESS : H_CUR_THREAD;
        end else begin
            req.kind = KIND_UNUSED;
        end
        return req;
    endfunction

    // Send one request, holding valid and payload until it is accepted.
    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_responses.push_back(predict_response(req));
        request_count++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [31:0] handle,
                               input logic [31:0] object_id, input logic [31:0] thread);
        in_item_t req;
        req.kind                  = kind;
        req.handle                = handle;
        req.object_id             = object_id;
        req.current_thread_handle = thread;
        send_request(req);
    endtask

    // Hold the request port idle until every owed response has come back.
    task automatic wait_for_responses();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_responses.size() != 0);
    endtask

    // Check each response against the oldest prediction.
    always @(posedge aclk) begin : check_responses
        out_item_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: response with no request outstanding, actual %h",
                         $time, m_item);
                failures++;
            end else begin
                expected = pending_responses.pop_front();
                if (m_item.status !== expected.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, expected.status, m_item.status);
                    failures++;
                end
                if (m_item.handle_out !== expected.handle_out) begin
                    $display("%0t: handle_out mismatch, expected %h, actual %h",
                             $time, expected.handle_out, m_item.handle_out);
                    failures++;
                end
                if (m_item.object_out !== expected.object_out) begin
                    $display("%0t: object_out mismatch, expected %h, actual %h",
                             $time, expected.object_out, m_item.object_out);
                    failures++;
                end
                case (expected.status)
                    ST_OK:   ok_count++;
                    ST_FULL: full_count++;
                    default: invalid_count++;
                endcase
            end
        end
    end

    // Field extremes, slot zero, low-bit masking, special handles, slot reuse
    // after remove, and the unused kind, on a nearly empty table.
    task automatic test_directed_cases();
        send_fields(KIND_GET, 32'h0000_0000, 32'h0, 32'h0);
        send_fields(KIND_REMOVE, 32'h0000_0003, 32'h0, 32'h0);
        send_fields(KIND_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0);
        send_fields(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(KIND_GET, 32'h0000_0004, 32'h0, 32'h0);
        send_fields(KIND_GET, 32'h0000_000B, 32'h0, 32'h0);
        send_fields(KIND_GET, H_CUR_THREAD, 32'h0, 32'h0000_0008);
        send_fields(KIND_GET, H_CUR_THREAD, 32'h0, 32'hFFFF_FFFF);
        send_fields(KIND_GET, H_CUR_PROCESS, 32'h0, 32'h0000_0008);
        send_fields(KIND_GET, 32'(TABLE_SLOTS * 4 - 4), 32'h0, 32'h0);
        send_fields(KIND_GET, 32'(TABLE_SLOTS * 4), 32'h0, 32'h0);
        send_fields(KIND_GET, 32'hFFFF_FFFC, 32'h0, 32'h0);
        wait_for_responses();
        send_fields(KIND_REMOVE, 32'h0000_0004, 32'h0, 32'h0);
        send_fields(KIND_GET, 32'h0000_0004, 32'h0, 32'h0);
        send_fields(KIND_REMOVE, 32'h0000_0004, 32'h0, 32'h0);
        send_fields(KIND_ADD, 32'h0, 32'hA5A5_5A5A, 32'h0);
        send_fields(KIND_GET, 32'h0000_0005, 32'h0, 32'h0);
        send_fields(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(KIND_REMOVE, H_CUR_THREAD, 32'h0, 32'h0000_0004);
        send_fields(KIND_REMOVE, H_CUR_PROCESS, 32'h0, 32'h0);
        send_fields(KIND_REMOVE, 32'h0000_0008, 32'h0, 32'h0);
        send_fields(KIND_REMOVE, 32'h0000_0006, 32'h0, 32'h0);
        wait_for_responses();
    endtask

    // Random traffic, with an occasional pause until the block drains.
    task automatic test_random_mix(input int count);
        repeat (count) begin
            send_request(random_request());
            if ($urandom_range(49) == 0)
                wait_for_responses();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_object[i] = '0;
        end
        live_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender stalls lightly while the receiver stalls heavily.
        send_idle_pct = 37;
        recv_idle_pct = 81;
        test_directed_cases();
        test_random_mix(250);

        // Stall rates swapped.
        send_idle_pct = 81;
        recv_idle_pct = 37;
        test_random_mix(250);

        // Back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(78);

        s_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d succeeded, %0d invalid, %0d table full.",
                 request_count, ok_count, invalid_count, full_count);
        $display("Stalls ran on either side and on neither; %0d slots held at the end.",
                 live_count);
        if (failures == 0) begin
            $display("handle_table_allocator_top verification clean");
        end else begin
            $display("handle_table_allocator_top verification failed");
        end
        $finish;
    end

endmodule
